// File: src/i128dec_pkg.sv
// Package for the signed 128-bit binary to packed BCD converter.
// Holds widths, pipeline geometry, data types and the shift-and-add-3 step.
// No dependencies.

package i128dec_pkg;

   // Field and datapath widths
   localparam int VALUE_W    = 128;
   localparam int HALF_W     = 64;
   localparam int NUM_DIGITS = 39;
   localparam int DIGIT_W    = 4;
   localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
   localparam int TOP_W      = BCD_W - 2 * HALF_W;
   localparam int COUNT_W    = 6;

   // Pipeline geometry: input bits consumed by each conversion stage
   localparam int BITS_PER_STAGE = 4;
   localparam int NUM_STAGES     = VALUE_W / BITS_PER_STAGE;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [BCD_W-1:0]   bcd_type;
   typedef logic [COUNT_W-1:0] count_type;

   // One double-dabble step: correct every digit of 5 or more by adding 3,
   // then shift the whole BCD word left by one with the new bit at the bottom.
   function automatic bcd_type dabble_bit(input bcd_type bcd, input logic new_bit);
      bcd_type             adj;
      logic [DIGIT_W-1:0]  dig;
      adj = bcd;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         dig = bcd[k*DIGIT_W +: DIGIT_W];
         if (dig >= 4'd5) begin
            adj[k*DIGIT_W +: DIGIT_W] = dig + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], new_bit};
   endfunction

   // Number of significant digits, leading zeros dropped, 1 for zero
   function automatic count_type digit_count(input bcd_type bcd);
      count_type cnt;
      cnt = COUNT_W'(1);
      for (int k = 0; k < NUM_DIGITS; k++) begin
         if (bcd[k*DIGIT_W +: DIGIT_W] != '0) begin
            cnt = COUNT_W'(k + 1);
         end
      end
      return cnt;
   endfunction

endpackage

// File: src/int128_to_signed_decimal_digits_unit.sv
// Top level of the signed 128-bit binary to packed BCD converter.
// Depends on i128dec_pkg for widths, types and the conversion step.

// Converts one 128-bit two's complement value per clock into 39 packed BCD
// digits of its magnitude, a significant digit count (1 for zero) and a sign
// flag. The most negative value converts to 2^127 exactly. In the pipeline,
// one stage takes the two's complement magnitude, 32 shift-and-add-3
// stages each consume four input bits, and a last stage finds the digit
// count and holds the result. A new transaction is taken every cycle while
// the result side is not stalled; a stalled result freezes the whole pipeline.

module int128_to_signed_decimal_digits_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [i128dec_pkg::HALF_W-1:0]    req_value_high,
   input  logic [i128dec_pkg::HALF_W-1:0]    req_value_low,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [i128dec_pkg::HALF_W-1:0]    rsp_digits_low,
   output logic [i128dec_pkg::HALF_W-1:0]    rsp_digits_mid,
   output logic [i128dec_pkg::TOP_W-1:0]     rsp_digits_top,
   output logic [i128dec_pkg::COUNT_W-1:0]   rsp_digit_count,
   output logic                              rsp_is_negative
);

   localparam int N   = i128dec_pkg::NUM_STAGES;
   localparam int BPS = i128dec_pkg::BITS_PER_STAGE;
   localparam int VW  = i128dec_pkg::VALUE_W;
   localparam int HW  = i128dec_pkg::HALF_W;

   // Pipeline registers
   logic [N:0]                   valid_ff;
   logic [N:0]                   neg_ff;
   i128dec_pkg::value_type       bin_ff [0:N-1];
   i128dec_pkg::bcd_type         bcd_ff [1:N];
   i128dec_pkg::bcd_type         bcd_in [1:N];

   logic                         rsp_valid_ff;
   i128dec_pkg::bcd_type         rsp_bcd_ff;
   i128dec_pkg::count_type       rsp_count_ff;
   i128dec_pkg::count_type       rsp_count_in;
   logic                         rsp_neg_ff;

   i128dec_pkg::value_type       raw_value;
   i128dec_pkg::value_type       mag_in;
   logic                         advance;

   // Whole pipeline moves unless a finished transaction is held at the output
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Magnitude: two's complement negation for negative inputs
   assign raw_value = {req_value_high, req_value_low};
   assign mag_in    = raw_value[VW-1] ? (~raw_value + VW'(1)) : raw_value;

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[N-1:0], req_valid};
         rsp_valid_ff <= valid_ff[N];
      end
   end

   // Entry stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         bin_ff[0] <= mag_in;
         neg_ff    <= {neg_ff[N-1:0], raw_value[VW-1]};
      end
   end

   // Conversion stages, four shift-and-add-3 steps each
   for (genvar i = 1; i <= N; i++) begin : g_stage
      i128dec_pkg::bcd_type bcd_prev;

      if (i == 1) begin : g_first
         assign bcd_prev = '0;
      end else begin : g_rest
         assign bcd_prev = bcd_ff[i-1];
      end

      always_comb begin
         bcd_in[i] = bcd_prev;
         for (int j = 0; j < BPS; j++) begin
            bcd_in[i] = i128dec_pkg::dabble_bit(bcd_in[i], bin_ff[i-1][VW-1-j]);
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            bcd_ff[i] <= bcd_in[i];
         end
      end

      // Remaining binary bits, consumed from the top
      if (i < N) begin : g_bin
         always_ff @(posedge clock) begin
            if (advance) begin
               bin_ff[i] <= bin_ff[i-1] << BPS;
            end
         end
      end
   end

   // Output stage: digit count and result hold register
   assign rsp_count_in = i128dec_pkg::digit_count(bcd_ff[N]);

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_bcd_ff   <= bcd_ff[N];
         rsp_count_ff <= rsp_count_in;
         rsp_neg_ff   <= neg_ff[N];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digits_low  = rsp_bcd_ff[HW-1:0];
   assign rsp_digits_mid  = rsp_bcd_ff[2*HW-1:HW];
   assign rsp_digits_top  = rsp_bcd_ff[i128dec_pkg::BCD_W-1:2*HW];
   assign rsp_digit_count = rsp_count_ff;
   assign rsp_is_negative = rsp_neg_ff;

   // A held result freezes every in-flight valid bit
   a_freeze_on_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(valid_ff))
      else $error("pipeline moved while result stalled");

   // A negative result never has a zero magnitude
   a_neg_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_negative |->
         (rsp_digits_low != '0) || (rsp_digits_mid != '0) || (rsp_digits_top != '0))
      else $error("negative result with zero magnitude");

   // Digit count stays within 1 to 39
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_count >= i128dec_pkg::COUNT_W'(1)) &&
         (rsp_digit_count <= i128dec_pkg::COUNT_W'(i128dec_pkg::NUM_DIGITS)))
      else $error("digit count out of range");

   // A full-length count has a nonzero leading digit
   a_full_count_lead : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_digit_count == i128dec_pkg::COUNT_W'(i128dec_pkg::NUM_DIGITS))
         |-> (rsp_digits_top[i128dec_pkg::TOP_W-1:i128dec_pkg::TOP_W-4] != '0))
      else $error("leading digit zero at full digit count");

endmodule

// File: tb/tb.sv
// Self-checking testbench for int128_to_signed_decimal_digits_unit.
// Streams directed and random 128-bit values and checks every result against an in-bench model.
// Depends on i128dec_pkg and the unit's top-level RTL.
`timescale 1ns / 100ps

module tb;

   localparam int VALUE_W    = i128dec_pkg::VALUE_W;
   localparam int HALF_W     = i128dec_pkg::HALF_W;
   localparam int TOP_W      = i128dec_pkg::TOP_W;
   localparam int COUNT_W    = i128dec_pkg::COUNT_W;
   localparam int NUM_DIGITS = i128dec_pkg::NUM_DIGITS;
   localparam int DIGIT_W    = i128dec_pkg::DIGIT_W;
   localparam int BCD_W      = i128dec_pkg::BCD_W;

   localparam int CLK_HALF_NS     = 6;
   localparam int RESET_CYCLES    = 5;
   localparam int RANDOM_ITEMS    = 1500;
   localparam int PIPE_LATENCY    = 34;
   localparam int HOLDOFF_CYCLES  = 150;
   localparam int TIMEOUT_NS      = 5_000_000;
   localparam int SLOW_IDLE_PCT   = 83;
   localparam int LIGHT_IDLE_PCT  = 35;

   // Traffic phases: who idles how often
   typedef enum logic [1:0] {
      PH_SEND_LIGHT,   // sender 35%, receiver 83%
      PH_SEND_HEAVY,   // sender 83%, receiver 35%
      PH_NO_IDLE
   } traffic_phase_type;

   // Shapes of random values
   typedef enum logic [1:0] {
      STIM_FULL,       // any 128-bit value
      STIM_NARROW,     // short magnitude, either sign
      STIM_DECADE,     // power of ten, exact or one off it, either sign
      STIM_NEAR_RAIL   // all zeros or all ones with one bit toggled
   } stim_kind_type;

   typedef struct packed {
      logic [HALF_W-1:0]  digits_low;
      logic [HALF_W-1:0]  digits_mid;
      logic [TOP_W-1:0]   digits_top;
      logic [COUNT_W-1:0] digit_count;
      logic               is_negative;
   } decimal_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [HALF_W-1:0]   req_value_high = '0;
   logic [HALF_W-1:0]   req_value_low = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [HALF_W-1:0]   rsp_digits_low;
   logic [HALF_W-1:0]   rsp_digits_mid;
   logic [TOP_W-1:0]    rsp_digits_top;
   logic [COUNT_W-1:0]  rsp_digit_count;
   logic                rsp_is_negative;

   logic [VALUE_W-1:0]  pending_values[$];
   decimal_result_type  expected_decimals[$];
   int                  total_items;
   int                  sent_count = 0;
   int                  checked_count = 0;
   int                  negative_count = 0;
   int                  backpressure_cycles = 0;
   int                  errors = 0;
   logic [NUM_DIGITS:0] counts_seen = '0;
   logic                req_taken = 1'b0;
   traffic_phase_type   phase = PH_SEND_LIGHT;

   int128_to_signed_decimal_digits_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value_high  (req_value_high),
      .req_value_low   (req_value_low),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digits_low  (rsp_digits_low),
      .rsp_digits_mid  (rsp_digits_mid),
      .rsp_digits_top  (rsp_digits_top),
      .rsp_digit_count (rsp_digit_count),
      .rsp_is_negative (rsp_is_negative)
   );

   always #(CLK_HALF_NS) clock = ~clock;

   // Decimal expansion of a two's complement value: magnitude by repeated division
   function automatic decimal_result_type to_decimal(input logic [VALUE_W-1:0] value);
      decimal_result_type res;
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] rem;
      logic [BCD_W-1:0]   bcd;
      logic [COUNT_W-1:0] cnt;
      mag = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
      bcd = '0;
      cnt = COUNT_W'(1);
      for (int k = 0; k < NUM_DIGITS; k++) begin
         rem = mag % VALUE_W'(10);
         mag = mag / VALUE_W'(10);
         bcd[k*DIGIT_W +: DIGIT_W] = rem[DIGIT_W-1:0];
         if (rem != '0) begin
            cnt = COUNT_W'(k + 1);
         end
      end
      res.digits_low  = bcd[HALF_W-1:0];
      res.digits_mid  = bcd[2*HALF_W-1:HALF_W];
      res.digits_top  = bcd[BCD_W-1:2*HALF_W];
      res.digit_count = cnt;
      res.is_negative = value[VALUE_W-1];
      return res;
   endfunction

   function automatic logic [VALUE_W-1:0] random_wide();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [VALUE_W-1:0] ten_to(input int exp10);
      logic [VALUE_W-1:0] p;
      p = VALUE_W'(1);
      for (int k = 0; k < exp10; k++) begin
         p = p * VALUE_W'(10);
      end
      return p;
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] v;
      stim_kind_type      kind;
      int                 flip_pos;
      kind = stim_kind_type'($urandom_range(0, 3));
      case (kind)
         STIM_FULL: begin
            v = random_wide();
         end
         STIM_NARROW: begin
            v = random_wide() >> $urandom_range(1, 127);
            if ($urandom_range(0, 1) == 1) begin
               v = ~v + VALUE_W'(1);
            end
         end
         STIM_DECADE: begin
            v = ten_to($urandom_range(0, NUM_DIGITS - 1));
            v = v + VALUE_W'($urandom_range(0, 2)) - VALUE_W'(1);
            if ($urandom_range(0, 1) == 1) begin
               v = ~v + VALUE_W'(1);
            end
         end
         default: begin
            v = ($urandom_range(0, 1) == 1) ? '1 : '0;
            flip_pos = $urandom_range(0, VALUE_W - 1);
            v[flip_pos] = ~v[flip_pos];
         end
      endcase
      return v;
   endfunction

   function automatic int idle_pct(input traffic_phase_type ph, input logic for_sender);
      case (ph)
         PH_SEND_LIGHT: return for_sender ? LIGHT_IDLE_PCT : SLOW_IDLE_PCT;
         PH_SEND_HEAVY: return for_sender ? SLOW_IDLE_PCT : LIGHT_IDLE_PCT;
         default:       return 0;
      endcase
   endfunction

   task automatic check_field(input string name, input logic [HALF_W-1:0] want,
                              input logic [HALF_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // Request driver: holds a stalled transaction, otherwise offers the next value
   always @(negedge clock) begin : drive_requests
      logic [VALUE_W-1:0] next_value;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (pending_values.size() != 0 &&
                   $urandom_range(0, 99) >= idle_pct(phase, 1'b1)) begin
         next_value = pending_values.pop_front();
         req_valid      <= 1'b1;
         req_value_high <= next_value[VALUE_W-1:HALF_W];
         req_value_low  <= next_value[HALF_W-1:0];
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result receiver: random stall, plus one long hold-off to fill the pipeline
   always @(negedge clock) begin : drive_result_stall
      int   holdoff_left;
      logic holdoff_done;
      if (reset) begin
         holdoff_left = 0;
         holdoff_done = 1'b0;
         rsp_stall <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else if (!holdoff_done && phase == PH_NO_IDLE &&
                   sent_count >= total_items - 400) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < idle_pct(phase, 1'b0));
      end
   end

   // Monitor: records accepted requests and checks accepted results
   always @(posedge clock) begin : monitor
      decimal_result_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_stall) begin
            backpressure_cycles++;
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            expected_decimals.push_back(to_decimal({req_value_high, req_value_low}));
            sent_count++;
            if (sent_count >= (2 * total_items) / 3) begin
               phase = PH_NO_IDLE;
            end else if (sent_count >= total_items / 3) begin
               phase = PH_SEND_HEAVY;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_decimals.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual count %0d",
                        $time, rsp_digit_count);
               errors++;
            end else begin
               want = expected_decimals.pop_front();
               check_field("digits_low", want.digits_low, rsp_digits_low);
               check_field("digits_mid", want.digits_mid, rsp_digits_mid);
               check_field("digits_top", HALF_W'(want.digits_top), HALF_W'(rsp_digits_top));
               check_field("digit_count", HALF_W'(want.digit_count),
                           HALF_W'(rsp_digit_count));
               check_field("is_negative", HALF_W'(want.is_negative),
                           HALF_W'(rsp_is_negative));
               counts_seen[want.digit_count] = 1'b1;
               if (want.is_negative) begin
                  negative_count++;
               end
               checked_count++;
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      logic [VALUE_W-1:0] most_neg;
      most_neg = {1'b1, {(VALUE_W-1){1'b0}}};
      // zero, smallest magnitudes and single-digit boundaries
      pending_values.push_back('0);
      pending_values.push_back(VALUE_W'(1));
      pending_values.push_back('1);
      pending_values.push_back(VALUE_W'(9));
      pending_values.push_back(VALUE_W'(10));
      pending_values.push_back(~VALUE_W'(10) + VALUE_W'(1));
      // rails: largest positive and most negative
      pending_values.push_back(~most_neg);
      pending_values.push_back(most_neg);
      pending_values.push_back(most_neg + VALUE_W'(1));
      // 39-digit territory
      pending_values.push_back(ten_to(38));
      pending_values.push_back(ten_to(38) - VALUE_W'(1));
      pending_values.push_back(~ten_to(38) + VALUE_W'(1));
      // half boundaries, alternating bit patterns and powers of ten near 19 digits
      pending_values.push_back({{HALF_W{1'b0}}, {HALF_W{1'b1}}});
      pending_values.push_back({{HALF_W{1'b1}}, {HALF_W{1'b0}}});
      pending_values.push_back(VALUE_W'(1) << HALF_W);
      pending_values.push_back(VALUE_W'(1) << (HALF_W - 1));
      pending_values.push_back({(VALUE_W/2){2'b01}});
      pending_values.push_back({(VALUE_W/2){2'b10}});
      pending_values.push_back(ten_to(19) - VALUE_W'(1));
      pending_values.push_back(ten_to(20));
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pending_values.push_back(random_value());
      end
      total_items = pending_values.size();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_values.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_decimals.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      $display("Converted %0d values (%0d negative) with %0d input stall cycles observed.",
               checked_count, negative_count, backpressure_cycles);
      $display("Distinct digit counts seen: %0d of %0d.", $countones(counts_seen), NUM_DIGITS);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d results still expected.", expected_decimals.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: filelist.f
src/i128dec_pkg.sv
src/int128_to_signed_decimal_digits_unit.sv
tb/tb.sv
